[rtl/cpfa_pkg.sv]
// shared types and constants of the contiguous page frame allocator
package cpfa_pkg;

   localparam int MAX_FRAMES  = 1024;
   localparam int FRAME_BYTES = 4096;

   localparam int IDX_W       = $clog2(MAX_FRAMES);
   localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
   localparam int COUNT_W     = 11;
   localparam int ADDR_W      = 32;
   localparam int FIRST_W     = 20;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_FRAME   = 1'b0,
      CSR_FRAMES_IN_USE = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic {
      KIND_FIXED = 1'b0,
      KIND_DIRTY = 1'b1
   } page_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NO_SPACE     = 2'd1,
      STATUS_BAD_FREE     = 2'd2,
      STATUS_ZERO_REQUEST = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FRAME_FREE  = 2'd0,
      FRAME_FIXED = 2'd1,
      FRAME_DIRTY = 2'd2,
      FRAME_UNUSED = 2'd3
   } frame_state_type;

   typedef enum logic [3:0] {
      ENG_CLEAR,
      ENG_IDLE,
      ENG_SCAN_START,
      ENG_SCAN,
      ENG_ALLOC_WRITE,
      ENG_FREE_READ,
      ENG_FREE_HEAD,
      ENG_FREE_WALK,
      ENG_DONE
   } eng_state_type;

   typedef struct packed {
      logic              command;
      logic [COUNT_W-1:0] request_pages;
      logic              page_kind;
      logic [ADDR_W-1:0] release_address;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  phys_address;
      logic [1:0]         status;
      logic [COUNT_W-1:0] free_frames;
   } rsp_payload_type;

   typedef struct packed {
      frame_state_type    state;
      logic [COUNT_W-1:0] run_length;
   } map_entry_type;

   localparam int MAP_W = $bits(map_entry_type);

   typedef struct packed {
      logic [FIRST_W-1:0] first_frame;
      logic [COUNT_W-1:0] managed;
      logic               reinit;
   } cfg_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      map_entry_type    wdata;
      logic [IDX_W-1:0] raddr;
   } map_access_type;

endpackage

[rtl/cpfa_map_ram.sv]
// frame map memory: one write port, one registered read port
module cpfa_map_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 13
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

[rtl/cpfa_engine.sv]
// allocation and release sequencer over the frame map
module cpfa_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  cpfa_pkg::req_payload_type req_payload,
   output logic                      req_ready,
   input  cpfa_pkg::cfg_type         cfg,
   input  logic                      out_free,
   output logic                      done,
   output cpfa_pkg::rsp_payload_type result,
   output cpfa_pkg::map_access_type  map_acc,
   input  logic [cpfa_pkg::MAP_W-1:0] map_rdata
);

   localparam int IW = cpfa_pkg::IDX_W;
   localparam int CW = cpfa_pkg::COUNT_W;
   localparam int AW = cpfa_pkg::ADDR_W;

   cpfa_pkg::eng_state_type state_ff, state_in;
   logic [IW-1:0]           cur_ff, cur_in;
   logic [IW-1:0]           head_ff, head_in;
   logic [CW-1:0]           len_ff, len_in;
   logic [CW-1:0]           remain_ff, remain_in;
   logic [CW-1:0]           lim_ff, lim_in;
   logic [CW-1:0]           pages_ff, pages_in;
   logic                    kind_ff, kind_in;
   logic [CW-1:0]           free_count_ff, free_count_in;
   logic [AW-1:0]           res_phys_ff, res_phys_in;
   cpfa_pkg::status_type    res_status_ff, res_status_in;

   cpfa_pkg::map_entry_type rd;
   logic                    accept;
   logic                    is_free_cmd;
   logic [CW-1:0]           pages;
   logic                    enough;
   logic [AW-1:0]           rel_idx;
   logic                    in_range;
   logic                    scan_free;
   logic [CW-1:0]           scan_len;
   logic [IW-1:0]           scan_head;
   logic                    scan_hit;
   logic                    scan_last;
   logic [CW:0]             run_end;
   logic [CW-1:0]           lim_c;
   logic [CW-1:0]           next_cur;
   logic                    walk_more;
   logic                    clear_last;

   assign rd          = cpfa_pkg::map_entry_type'(map_rdata);
   assign req_ready   = (state_ff == cpfa_pkg::ENG_IDLE) && !cfg.reinit;
   assign accept      = req_valid && req_ready;
   assign is_free_cmd = (req_payload.command == cpfa_pkg::CMD_FREE);
   assign pages       = req_payload.request_pages;
   assign enough      = (pages == CW'(1)) ? (free_count_ff != '0) : (free_count_ff > pages);

   assign rel_idx  = (req_payload.release_address >> cpfa_pkg::FRAME_SHIFT)
                     - AW'(cfg.first_frame);
   assign in_range = rel_idx < AW'(cfg.managed);

   assign scan_free = (rd.state == cpfa_pkg::FRAME_FREE);
   assign scan_len  = scan_free ? len_ff + CW'(1) : '0;
   assign scan_head = (scan_free && len_ff == '0) ? cur_ff : head_ff;
   assign scan_hit  = scan_free && (scan_len == pages_ff);
   assign scan_last = (CW'(cur_ff) == cfg.managed - CW'(1));

   assign run_end   = (CW+1)'(cur_ff) + (CW+1)'(rd.run_length);
   assign lim_c     = (state_ff == cpfa_pkg::ENG_FREE_HEAD)
                      ? ((run_end < (CW+1)'(cfg.managed)) ? run_end[CW-1:0] : cfg.managed)
                      : lim_ff;
   assign next_cur  = CW'(cur_ff) + CW'(1);
   assign walk_more = next_cur < lim_c;

   assign clear_last = (cur_ff == IW'(cpfa_pkg::MAX_FRAMES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cpfa_pkg::ENG_CLEAR: begin
            if (clear_last) state_in = cpfa_pkg::ENG_IDLE;
         end
         cpfa_pkg::ENG_IDLE: begin
            if (accept) begin
               if (is_free_cmd) begin
                  state_in = in_range ? cpfa_pkg::ENG_FREE_READ : cpfa_pkg::ENG_DONE;
               end else if (pages == '0 || !enough) begin
                  state_in = cpfa_pkg::ENG_DONE;
               end else begin
                  state_in = cpfa_pkg::ENG_SCAN_START;
               end
            end
         end
         cpfa_pkg::ENG_SCAN_START: state_in = cpfa_pkg::ENG_SCAN;
         cpfa_pkg::ENG_SCAN: begin
            if (scan_hit) state_in = cpfa_pkg::ENG_ALLOC_WRITE;
            else if (scan_last) state_in = cpfa_pkg::ENG_DONE;
         end
         cpfa_pkg::ENG_ALLOC_WRITE: begin
            if (remain_ff == CW'(1)) state_in = cpfa_pkg::ENG_DONE;
         end
         cpfa_pkg::ENG_FREE_READ: state_in = cpfa_pkg::ENG_FREE_HEAD;
         cpfa_pkg::ENG_FREE_HEAD: begin
            if (rd.run_length == '0 || !walk_more) state_in = cpfa_pkg::ENG_DONE;
            else state_in = cpfa_pkg::ENG_FREE_WALK;
         end
         cpfa_pkg::ENG_FREE_WALK: begin
            if (!walk_more) state_in = cpfa_pkg::ENG_DONE;
         end
         cpfa_pkg::ENG_DONE: begin
            if (out_free) state_in = cpfa_pkg::ENG_IDLE;
         end
         default: state_in = cpfa_pkg::ENG_CLEAR;
      endcase
      if (cfg.reinit) state_in = cpfa_pkg::ENG_CLEAR;
   end

   // outputs and datapath
   always_comb begin
      cur_in        = cur_ff;
      head_in       = head_ff;
      len_in        = len_ff;
      remain_in     = remain_ff;
      lim_in        = lim_ff;
      pages_in      = pages_ff;
      kind_in       = kind_ff;
      free_count_in = free_count_ff;
      res_phys_in   = res_phys_ff;
      res_status_in = res_status_ff;
      map_acc       = '0;
      map_acc.raddr = cur_ff;
      done          = 1'b0;

      unique case (state_ff)
         cpfa_pkg::ENG_CLEAR: begin
            map_acc.we    = 1'b1;
            map_acc.waddr = cur_ff;
            cur_in        = cur_ff + IW'(1);
         end
         cpfa_pkg::ENG_IDLE: begin
            if (accept) begin
               pages_in      = pages;
               kind_in       = req_payload.page_kind;
               res_phys_in   = '0;
               res_status_in = cpfa_pkg::STATUS_OK;
               cur_in        = rel_idx[IW-1:0];
               if (is_free_cmd) begin
                  if (!in_range) res_status_in = cpfa_pkg::STATUS_BAD_FREE;
               end else if (pages == '0) begin
                  res_status_in = cpfa_pkg::STATUS_ZERO_REQUEST;
               end else if (!enough) begin
                  res_status_in = cpfa_pkg::STATUS_NO_SPACE;
               end
            end
         end
         cpfa_pkg::ENG_SCAN_START: begin
            map_acc.raddr = '0;
            cur_in        = '0;
            len_in        = '0;
            head_in       = '0;
         end
         cpfa_pkg::ENG_SCAN: begin
            map_acc.raddr = cur_ff + IW'(1);
            cur_in        = cur_ff + IW'(1);
            len_in        = scan_len;
            head_in       = scan_head;
            if (scan_hit) begin
               cur_in    = scan_head;
               remain_in = pages_ff;
            end else if (scan_last) begin
               res_status_in = cpfa_pkg::STATUS_NO_SPACE;
            end
         end
         cpfa_pkg::ENG_ALLOC_WRITE: begin
            map_acc.we               = 1'b1;
            map_acc.waddr            = cur_ff;
            map_acc.wdata.state      = kind_ff ? cpfa_pkg::FRAME_DIRTY : cpfa_pkg::FRAME_FIXED;
            map_acc.wdata.run_length = (cur_ff == head_ff) ? pages_ff : '0;
            cur_in                   = cur_ff + IW'(1);
            remain_in                = remain_ff - CW'(1);
            if (remain_ff == CW'(1)) begin
               free_count_in = free_count_ff - pages_ff;
               res_phys_in   = (AW'(cfg.first_frame) + AW'(head_ff)) << cpfa_pkg::FRAME_SHIFT;
            end
         end
         cpfa_pkg::ENG_FREE_READ: begin
            map_acc.raddr = cur_ff;
         end
         cpfa_pkg::ENG_FREE_HEAD, cpfa_pkg::ENG_FREE_WALK: begin
            if (state_ff == cpfa_pkg::ENG_FREE_HEAD && rd.run_length == '0) begin
               res_status_in = cpfa_pkg::STATUS_BAD_FREE;
            end else begin
               map_acc.we    = 1'b1;
               map_acc.waddr = cur_ff;
               map_acc.raddr = cur_ff + IW'(1);
               cur_in        = cur_ff + IW'(1);
               lim_in        = lim_c;
               if (rd.state != cpfa_pkg::FRAME_FREE) free_count_in = free_count_ff + CW'(1);
            end
         end
         cpfa_pkg::ENG_DONE: begin
            done = out_free;
         end
         default: begin
            cur_in = '0;
         end
      endcase

      if (cfg.reinit) begin
         cur_in        = '0;
         free_count_in = cfg.managed;
      end
   end

   assign result.phys_address = res_phys_ff;
   assign result.status       = res_status_ff;
   assign result.free_frames  = free_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cpfa_pkg::ENG_CLEAR;
         cur_ff        <= '0;
         free_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         free_count_ff <= free_count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff       <= head_in;
      len_ff        <= len_in;
      remain_ff     <= remain_in;
      lim_ff        <= lim_in;
      pages_ff      <= pages_in;
      kind_ff       <= kind_in;
      res_phys_ff   <= res_phys_in;
      res_status_ff <= res_status_in;
   end

endmodule

[rtl/contiguous_page_frame_allocator_core.sv]
// top level of the contiguous page frame allocator: registers, map memory, result register
//
// First-fit contiguous page frame allocator over a map of up to 1024 frames held in one
// single-port-read memory that is visited one entry per cycle. One request is worked at a
// time and gives one response. An allocate request scans the map up to the end of the
// first fitting run, or to the end of the map if none fits, then writes one entry per page;
// a free request writes one entry per frame of the run. Zero requests, requests refused on
// the free count and out-of-range frees answer without a pass over the map. After reset
// and after every write of frames_in_use the map is cleared in one pass over all 1024
// entries, during which no request is accepted. The response waits in an output register,
// so the next request can be taken while it is unread.
module contiguous_page_frame_allocator_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  cpfa_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cpfa_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_we,
   input  logic [cpfa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cpfa_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CW = cpfa_pkg::COUNT_W;

   logic [cpfa_pkg::FIRST_W-1:0] first_frame_ff, first_frame_in;
   logic [CW-1:0]                frames_in_use_ff, frames_in_use_in;
   logic                         reinit_ff, reinit_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   cpfa_pkg::rsp_payload_type    rsp_payload_ff;

   cpfa_pkg::cfg_type            cfg;
   cpfa_pkg::map_access_type     map_acc;
   logic [cpfa_pkg::MAP_W-1:0]   map_rdata;
   logic                         out_free;
   logic                         done;
   cpfa_pkg::rsp_payload_type    result;

   always_comb begin
      first_frame_in   = first_frame_ff;
      frames_in_use_in = frames_in_use_ff;
      reinit_in        = 1'b0;
      if (csr_we) begin
         unique case (cpfa_pkg::csr_index_type'(csr_index))
            cpfa_pkg::CSR_FIRST_FRAME: begin
               first_frame_in = csr_wdata[cpfa_pkg::FIRST_W-1:0];
            end
            cpfa_pkg::CSR_FRAMES_IN_USE: begin
               frames_in_use_in = csr_wdata[CW-1:0];
               reinit_in        = 1'b1;
            end
            default: begin
               first_frame_in = first_frame_ff;
            end
         endcase
      end
   end

   assign cfg.first_frame = first_frame_ff;
   assign cfg.managed     = (frames_in_use_ff > CW'(cpfa_pkg::MAX_FRAMES))
                            ? CW'(cpfa_pkg::MAX_FRAMES) : frames_in_use_ff;
   assign cfg.reinit      = reinit_ff;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         first_frame_ff   <= '0;
         frames_in_use_ff <= CW'(1024);
         reinit_ff        <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         first_frame_ff   <= first_frame_in;
         frames_in_use_ff <= frames_in_use_in;
         reinit_ff        <= reinit_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   cpfa_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_ready   (req_ready),
      .cfg         (cfg),
      .out_free    (out_free),
      .done        (done),
      .result      (result),
      .map_acc     (map_acc),
      .map_rdata   (map_rdata)
   );

   cpfa_map_ram #(
      .DEPTH (cpfa_pkg::MAX_FRAMES),
      .WIDTH (cpfa_pkg::MAP_W)
   ) u_map_ram (
      .clock (clock),
      .we    (map_acc.we),
      .waddr (map_acc.waddr),
      .wdata (map_acc.wdata),
      .raddr (map_acc.raddr),
      .rdata (map_rdata)
   );

endmodule

[test/frame_map_checker.sv]
// checker of the page frame allocator: models the frame map and compares every response
`timescale 1ns / 100ps

module frame_map_checker
   import cpfa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  req_payload_type         req_payload,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rsp_payload_type         rsp_payload,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int                      mismatches,
   output int                      outstanding,
   output int                      granted,
   output int                      released,
   output int                      refused
);

   frame_state_type    map_state [MAX_FRAMES];
   logic [COUNT_W-1:0] head_len [MAX_FRAMES];
   logic [COUNT_W-1:0] free_cnt;
   logic [FIRST_W-1:0] base_frame;
   logic [COUNT_W-1:0] frame_limit;
   rsp_payload_type    awaited_rsp [$];

   function automatic int managed_frames();
      return (frame_limit > MAX_FRAMES) ? MAX_FRAMES : int'(frame_limit);
   endfunction

   function automatic void clear_frame_map();
      for (int i = 0; i < MAX_FRAMES; i++) begin
         map_state[i] = FRAME_FREE;
         head_len[i]  = '0;
      end
      free_cnt = COUNT_W'(managed_frames());
   endfunction

   function automatic rsp_payload_type serve_request(req_payload_type rq);
      rsp_payload_type r;
      int              count;
      int              len;
      int              head;
      int              i;
      logic [31:0]     idx;
      logic [63:0]     addr;
      logic            enough;
      r        = '0;
      r.status = STATUS_OK;
      count    = managed_frames();
      if (rq.command == CMD_ALLOC) begin
         enough = (rq.request_pages == 1) ? (free_cnt >= 1) : (free_cnt > rq.request_pages);
         if (rq.request_pages == 0) begin
            r.status = STATUS_ZERO_REQUEST;
         end else if (!enough) begin
            r.status = STATUS_NO_SPACE;
         end else begin
            len  = 0;
            head = 0;
            for (i = 0; i < count && len != int'(rq.request_pages); i++) begin
               if (map_state[i] == FRAME_FREE) begin
                  if (len == 0) head = i;
                  len++;
               end else begin
                  len = 0;
               end
            end
            if (len != int'(rq.request_pages)) begin
               r.status = STATUS_NO_SPACE;
            end else begin
               for (i = head; i < head + len && i < MAX_FRAMES; i++) begin
                  map_state[i] = rq.page_kind ? FRAME_DIRTY : FRAME_FIXED;
                  head_len[i]  = '0;
                  free_cnt     = free_cnt - 1'b1;
               end
               head_len[head] = rq.request_pages;
               addr           = (64'(base_frame) + 64'(head)) * FRAME_BYTES;
               r.phys_address = addr[31:0];
            end
         end
      end else begin
         idx = (rq.release_address >> FRAME_SHIFT) - 32'(base_frame);
         if (idx >= count || head_len[idx[IDX_W-1:0]] == 0) begin
            r.status = STATUS_BAD_FREE;
         end else begin
            len = int'(head_len[idx[IDX_W-1:0]]);
            for (i = int'(idx); i < int'(idx) + len && i < count; i++) begin
               if (map_state[i] != FRAME_FREE) free_cnt = free_cnt + 1'b1;
               map_state[i] = FRAME_FREE;
               head_len[i]  = '0;
            end
         end
      end
      if (r.status == STATUS_OK) begin
         if (rq.command == CMD_ALLOC) granted++;
         else released++;
      end else begin
         refused++;
      end
      r.free_frames = free_cnt;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         base_frame  = '0;
         frame_limit = COUNT_W'(MAX_FRAMES);
         clear_frame_map();
         awaited_rsp.delete();
         mismatches  = 0;
         granted     = 0;
         released    = 0;
         refused     = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FIRST_FRAME: begin
                  base_frame = csr_wdata[FIRST_W-1:0];
               end
               CSR_FRAMES_IN_USE: begin
                  frame_limit = csr_wdata[COUNT_W-1:0];
                  clear_frame_map();
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready) awaited_rsp.push_back(serve_request(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, got %h", $time, rsp_payload);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_payload.phys_address !== want.phys_address) begin
                  mismatches++;
                  $display("%0t: phys_address expected %h got %h", $time,
                           want.phys_address, rsp_payload.phys_address);
               end
               if (rsp_payload.status !== want.status) begin
                  mismatches++;
                  $display("%0t: status expected %0d got %0d", $time,
                           want.status, rsp_payload.status);
               end
               if (rsp_payload.free_frames !== want.free_frames) begin
                  mismatches++;
                  $display("%0t: free_frames expected %0d got %0d", $time,
                           want.free_frames, rsp_payload.free_frames);
               end
            end
         end
      end
      outstanding = awaited_rsp.size();
   end

endmodule

[test/testbench.sv]
// top of the page frame allocator testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module testbench;
   import cpfa_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_payload_type        req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_payload_type        rsp_payload;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatches;
   int outstanding;
   int granted;
   int released;
   int refused;

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int hold_request    = 0;
   int hold_served     = 0;
   int requests_sent   = 0;
   int settings_used   = 1;

   logic [31:0] live_heads [$];
   command_type issued_cmds [$];

   always #5 clock = ~clock;

   contiguous_page_frame_allocator_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   frame_map_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .granted     (granted),
      .released    (released),
      .refused     (refused)
   );

   // granted run heads feed free requests, most of them well-formed
   always @(posedge clock) begin
      command_type cmd;
      if (!reset) begin
         if (req_valid && req_ready) issued_cmds.push_back(command_type'(req_payload.command));
         if (rsp_valid && rsp_ready && issued_cmds.size() != 0) begin
            cmd = issued_cmds.pop_front();
            if (cmd == CMD_ALLOC && rsp_payload.status == STATUS_OK)
               live_heads.push_back(rsp_payload.phys_address);
         end
      end
   end

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != hold_served) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_served = hold_request;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      #100_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic req_payload_type make_request(command_type cmd, int pages,
                                                    page_kind_type kind, logic [31:0] addr);
      req_payload_type rq;
      rq.command         = cmd;
      rq.request_pages   = COUNT_W'(pages);
      rq.page_kind       = kind;
      rq.release_address = addr;
      return rq;
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type rq;
      int              roll;
      int              pick;
      rq.command         = CMD_ALLOC;
      rq.request_pages   = COUNT_W'($urandom);
      rq.page_kind       = 1'($urandom_range(1));
      rq.release_address = $urandom;
      roll = $urandom_range(99);
      if (roll < 8) begin
         rq.command = CMD_FREE;
      end else if (live_heads.size() == 0 || roll < 58) begin
         roll = $urandom_range(99);
         if (roll < 55)      rq.request_pages = COUNT_W'($urandom_range(1, 4));
         else if (roll < 82) rq.request_pages = COUNT_W'($urandom_range(5, 24));
         else if (roll < 89) rq.request_pages = '0;
         else if (roll < 94) rq.request_pages = 11'd1;
         else if (roll < 97) rq.request_pages = COUNT_W'($urandom_range(25, 1024));
         else                rq.request_pages = COUNT_W'($urandom_range(1025, 2047));
      end else begin
         rq.command = CMD_FREE;
         pick = $urandom_range(live_heads.size() - 1);
         roll = $urandom_range(99);
         if (roll < 85) begin
            rq.release_address = live_heads[pick] | 32'($urandom_range(4095));
            live_heads.delete(pick);
         end else begin
            rq.release_address = live_heads[pick] + 32'h1000;
         end
      end
      return rq;
   endfunction

   task automatic offer_request(input req_payload_type rq);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input int frames, input int first, input int send_idle,
                            input int stall, input int count, input int hold_at,
                            input int pause_at);
      settle();
      write_register(CSR_FIRST_FRAME, CSR_DATA_W'(first));
      write_register(CSR_FRAMES_IN_USE, CSR_DATA_W'(frames));
      live_heads.delete();
      settings_used++;
      sender_idle_pct = send_idle;
      rsp_stall_pct   = stall;
      for (int k = 0; k < count; k++) begin
         if (k == hold_at) hold_request++;
         if (k == pause_at) begin
            req_valid <= 1'b0;
            @(posedge clock);
            wait (outstanding == 0);
         end
         offer_request(random_request());
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_we      <= 1'b0;
      csr_index   <= CSR_FIRST_FRAME;
      csr_wdata   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed requests on the reset map
      offer_request(make_request(CMD_ALLOC, 0, KIND_FIXED, $urandom));
      offer_request(make_request(CMD_ALLOC, 1, KIND_FIXED, $urandom));
      offer_request(make_request(CMD_FREE, $urandom_range(2047), KIND_DIRTY, 32'h0));
      offer_request(make_request(CMD_ALLOC, 1024, KIND_DIRTY, $urandom));
      offer_request(make_request(CMD_ALLOC, 1023, KIND_DIRTY, $urandom));
      offer_request(make_request(CMD_ALLOC, 1, KIND_FIXED, $urandom));
      offer_request(make_request(CMD_ALLOC, 1, KIND_DIRTY, $urandom));
      offer_request(make_request(CMD_FREE, 2047, KIND_FIXED, 32'h0000_0fff));
      offer_request(make_request(CMD_FREE, 0, KIND_DIRTY, 32'h003f_f123));
      offer_request(make_request(CMD_FREE, 1, KIND_FIXED, 32'hffff_ffff));
      offer_request(make_request(CMD_FREE, 3, KIND_DIRTY, 32'h0000_1000));
      offer_request(make_request(CMD_ALLOC, 2047, KIND_FIXED, 32'hffff_ffff));
      offer_request(make_request(CMD_ALLOC, 3, KIND_FIXED, $urandom));
      offer_request(make_request(CMD_ALLOC, 2, KIND_DIRTY, $urandom));
      offer_request(make_request(CMD_FREE, 1024, KIND_FIXED, 32'h0000_0000));
      offer_request(make_request(CMD_ALLOC, 2, KIND_DIRTY, $urandom));
      offer_request(make_request(CMD_ALLOC, 4, KIND_FIXED, $urandom));

      // top of the frame number range, addresses wrap
      settle();
      write_register(CSR_FIRST_FRAME, 20'hfffff);
      settings_used++;
      offer_request(make_request(CMD_ALLOC, 1, KIND_DIRTY, $urandom));
      offer_request(make_request(CMD_FREE, 5, KIND_FIXED, 32'hffff_f000));
      offer_request(make_request(CMD_FREE, 0, KIND_DIRTY, 32'h0000_1000));

      run_phase(1024, 0, 0, 0, 120, 30, -1);
      run_phase(64, $urandom_range(20'hfffff), 80, 0, 80, -1, -1);
      run_phase(16, 20'hfffff, 0, 80, 80, -1, -1);
      run_phase(2047, $urandom_range(20'hfffff), 26, 26, 100, 40, -1);
      run_phase(0, $urandom_range(20'hfffff), 0, 0, 10, -1, -1);
      run_phase(1, 0, 26, 26, 30, -1, 15);
      run_phase(2, $urandom_range(20'hfffff), 80, 80, 40, -1, -1);
      run_phase(300, $urandom_range(20'hfffff), 0, 0, 100, -1, 50);

      settle();
      repeat (2100) @(posedge clock);

      $display("%0d requests over %0d map settings: %0d runs granted, %0d released, %0d refused",
               requests_sent, settings_used, granted, released, refused);
      $display("idle mixes: none, sender 80%%, receiver 80%%, both 26%%, both 80%%, long holds");
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
